/* rtl/mmrc_pkg.sv */
package mmrc_pkg;

  localparam int MaxEntries = 32;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int CfgIdxW    = 2;

  localparam logic [1:0] KindClear  = 2'd0;
  localparam logic [1:0] KindAppend = 2'd1;
  localparam logic [1:0] KindCarve  = 2'd2;
  localparam logic [1:0] KindRead   = 2'd3;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusOor  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgRamType      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgReservedType = CfgIdxW'(1);

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [31:0] kind;
  } entry_t;

endpackage

/* rtl/memory_map_range_carver.sv */
// Memory-map range carver.
// Command channel: raise start_i with kind_i and the operand fields; the item is
// taken at a clock edge where start_i is high and busy_o is low. Kinds: clear the
// table, append one entry, carve [range_start_i, range_end_i) out of all RAM
// entries, or read the entry at index_i.
// Result: one item per command, shown for exactly one cycle with result_valid_o
// high. The receiver cannot stall; the result must be taken in that cycle.
// Clear and append answer in the cycle after acceptance; a read answers from
// S_READ after the table read; a carve, once its sweep has drained. The carve
// sweeps the table through its single read port, one entry issued per cycle,
// with a read / update / write pipeline behind it; busy_o stays high until the
// result is shown, so a new command may start in the cycle of the result strobe.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is the RAM type code, index 1 the reserved type code. Write only
// while the block is idle.
// Reset: the entry count clears to zero and the type codes go to 1 and 2;
// table contents are undefined until written and need no clearing pass.
module memory_map_range_carver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    kind_i,
  input  logic [4:0]                    index_i,
  input  logic [63:0]                   entry_base_i,
  input  logic [63:0]                   entry_length_i,
  input  logic [31:0]                   entry_type_i,
  input  logic [63:0]                   range_start_i,
  input  logic [63:0]                   range_end_i,
  output logic                          result_valid_o,
  output logic [63:0]                   out_base_o,
  output logic [63:0]                   out_length_o,
  output logic [31:0]                   out_type_o,
  output logic [5:0]                    used_count_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mmrc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import mmrc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SWEEP
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [31:0]       ram_code_q;
  logic [31:0]       rsv_code_q;
  logic [63:0]       rs_q;
  logic [63:0]       re_q;
  logic              rd_ok_q;
  logic [CntW-1:0]   rd_ptr_q;
  logic              rd_v_q;
  logic [IdxW-1:0]   rd_addr_q;
  logic              ex_v_q;
  logic [IdxW-1:0]   ex_addr_q;
  entry_t            ex_ent_q;
  logic [63:0]       ex_end_q;
  logic              have_rem_q;
  logic [63:0]       rem_len_q;

  logic              res_v_q;
  logic [63:0]       res_base_q;
  logic [63:0]       res_len_q;
  logic [31:0]       res_type_q;
  logic [1:0]        res_status_q;

  // table
  entry_t            mem_q [MaxEntries];
  entry_t            mem_rdata_q;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  entry_t            mem_wdata;

  logic              accept;
  logic              not_full;
  logic              sweep_done;
  logic              rem_push;
  logic              skip;
  logic              tail_cut;
  logic              spans;
  logic              enclosed;
  entry_t            upd_ent;
  logic [63:0]       cut_len;
  logic [63:0]       over_len;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign not_full    = (count_q < CntW'(MaxEntries));
  assign sweep_done  = (state_q == S_SWEEP) && (rd_ptr_q == count_q) && !rd_v_q && !ex_v_q;
  assign rem_push    = sweep_done && have_rem_q && (rem_len_q != 64'd0);

  // update of the entry in the last pipeline stage
  always_comb begin
    cut_len  = rs_q - ex_ent_q.base;
    over_len = ex_end_q - re_q;
    skip     = (ex_ent_q.kind != ram_code_q) || (ex_end_q <= rs_q) || (ex_ent_q.base >= re_q);
    tail_cut = ex_ent_q.base < rs_q;
    spans    = tail_cut && (ex_end_q > re_q);
    enclosed = !tail_cut && (ex_end_q <= re_q);
    upd_ent  = ex_ent_q;
    if (tail_cut) begin
      upd_ent.length = cut_len;
    end else if (enclosed) begin
      upd_ent.kind = rsv_code_q;
    end else begin
      upd_ent.base   = re_q;
      upd_ent.length = over_len;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_ptr_q[IdxW-1:0];
    if (accept && (kind_i == KindRead)) begin
      mem_re    = 1'b1;
      mem_raddr = IdxW'(index_i);
    end else if ((state_q == S_SWEEP) && (rd_ptr_q < count_q)) begin
      mem_re = 1'b1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IdxW-1:0];
    mem_wdata = '{base: entry_base_i, length: entry_length_i, kind: entry_type_i};
    if (accept && (kind_i == KindAppend)) begin
      mem_we = not_full;
    end else if (ex_v_q) begin
      mem_we    = !skip;
      mem_waddr = ex_addr_q;
      mem_wdata = upd_ent;
    end else if (rem_push) begin
      mem_we    = not_full;
      mem_wdata = '{base: re_q, length: rem_len_q, kind: ram_code_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      ram_code_q   <= 32'd1;
      rsv_code_q   <= 32'd2;
      rs_q         <= '0;
      re_q         <= '0;
      rd_ok_q      <= 1'b0;
      rd_ptr_q     <= '0;
      rd_v_q       <= 1'b0;
      rd_addr_q    <= '0;
      ex_v_q       <= 1'b0;
      ex_addr_q    <= '0;
      ex_ent_q     <= '0;
      ex_end_q     <= '0;
      have_rem_q   <= 1'b0;
      rem_len_q    <= '0;
      res_v_q      <= 1'b0;
      res_base_q   <= '0;
      res_len_q    <= '0;
      res_type_q   <= '0;
      res_status_q <= StatusOk;
    end else begin
      res_v_q <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgRamType) begin
          ram_code_q <= cfg_data_i;
        end else if (cfg_index_i == CfgReservedType) begin
          rsv_code_q <= cfg_data_i;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_base_q   <= '0;
            res_len_q    <= '0;
            res_type_q   <= '0;
            res_status_q <= StatusOk;
            case (kind_i)
              KindClear: begin
                count_q <= '0;
                res_v_q <= 1'b1;
              end
              KindAppend: begin
                res_v_q <= 1'b1;
                if (not_full) begin
                  count_q <= count_q + CntW'(1);
                end else begin
                  res_status_q <= StatusFull;
                end
              end
              KindCarve: begin
                rs_q       <= range_start_i;
                re_q       <= range_end_i;
                rd_ptr_q   <= '0;
                rd_v_q     <= 1'b0;
                ex_v_q     <= 1'b0;
                have_rem_q <= 1'b0;
                state_q    <= S_SWEEP;
              end
              default: begin
                rd_ok_q <= (CntW'(index_i) < count_q);
                state_q <= S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          res_v_q <= 1'b1;
          if (rd_ok_q) begin
            res_base_q <= mem_rdata_q.base;
            res_len_q  <= mem_rdata_q.length;
            res_type_q <= mem_rdata_q.kind;
          end else begin
            res_status_q <= StatusOor;
          end
          state_q <= S_IDLE;
        end
        S_SWEEP: begin
          // issue one read per cycle, then add, then update and write back
          rd_v_q    <= mem_re;
          rd_addr_q <= rd_ptr_q[IdxW-1:0];
          if (mem_re) begin
            rd_ptr_q <= rd_ptr_q + CntW'(1);
          end
          ex_v_q    <= rd_v_q;
          ex_addr_q <= rd_addr_q;
          ex_ent_q  <= mem_rdata_q;
          ex_end_q  <= mem_rdata_q.base + mem_rdata_q.length;
          if (ex_v_q && !skip && spans) begin
            have_rem_q <= 1'b1;
            rem_len_q  <= over_len;
          end
          if (sweep_done) begin
            res_v_q <= 1'b1;
            if (rem_push) begin
              if (not_full) begin
                count_q <= count_q + CntW'(1);
              end else begin
                res_status_q <= StatusFull;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = res_v_q;
  assign out_base_o     = res_base_q;
  assign out_length_o   = res_len_q;
  assign out_type_o     = res_type_q;
  assign used_count_o   = 6'(count_q);
  assign status_o       = res_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("entry count above table size");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> (state_q == S_IDLE))
    else $error("result shown while busy");

  a_clear_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KindClear)) |=> (res_v_q && (count_q == '0)))
    else $error("clear did not complete in one cycle");

  a_pipe_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_v_q || ex_v_q) |-> (state_q == S_SWEEP))
    else $error("carve pipeline active outside a carve");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !mem_we)
    else $error("table written during a read");

endmodule

/* bench/memory_map_range_carver_test.sv */
`timescale 1ns / 1ps

module memory_map_range_carver_test;
  import mmrc_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  index;
    logic [63:0] base;
    logic [63:0] length;
    logic [31:0] etype;
    logic [63:0] rstart;
    logic [63:0] rend;
  } map_cmd_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [31:0] etype;
    logic [5:0]  used;
    logic [1:0]  status;
  } map_result_t;

  typedef struct packed {
    map_cmd_t   cmd;
    logic       fixed;
    logic [5:0] fixed_used;
    logic [1:0] fixed_status;
    logic       fill;
  } plan_row_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start_i        = 1'b0;
  logic                busy_o;
  logic [1:0]          kind_i         = KindClear;
  logic [4:0]          index_i        = '0;
  logic [63:0]         entry_base_i   = '0;
  logic [63:0]         entry_length_i = '0;
  logic [31:0]         entry_type_i   = '0;
  logic [63:0]         range_start_i  = '0;
  logic [63:0]         range_end_i    = '0;
  logic                result_valid_o;
  logic [63:0]         out_base_o;
  logic [63:0]         out_length_o;
  logic [31:0]         out_type_o;
  logic [5:0]          used_count_o;
  logic [1:0]          status_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = CfgRamType;
  logic [31:0]         cfg_data_i     = '0;

  memory_map_range_carver DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the entry table and the type codes
  logic [63:0] shadow_base [MaxEntries];
  logic [63:0] shadow_len  [MaxEntries];
  logic [31:0] shadow_type [MaxEntries];
  int unsigned shadow_count;
  logic [31:0] ram_code;
  logic [31:0] rsv_code;

  map_result_t pending_q[$];
  plan_row_t   plan_q[$];
  int unsigned fail_count;
  bit          start_up;

  function automatic logic shadow_append(logic [63:0] b, logic [63:0] l, logic [31:0] t);
    if (shadow_count >= MaxEntries) return 1'b0;
    shadow_base[shadow_count] = b;
    shadow_len[shadow_count]  = l;
    shadow_type[shadow_count] = t;
    shadow_count++;
    return 1'b1;
  endfunction

  function automatic logic [1:0] shadow_carve(logic [63:0] rs, logic [63:0] re);
    logic        have_rem;
    logic [63:0] rem_base;
    logic [63:0] rem_len;
    logic [63:0] b;
    logic [63:0] e;
    have_rem = 1'b0;
    rem_base = '0;
    rem_len  = '0;
    for (int i = 0; i < int'(shadow_count); i++) begin
      b = shadow_base[i];
      e = b + shadow_len[i];
      if (shadow_type[i] != ram_code || e <= rs || b >= re) continue;
      if (b < rs) begin
        shadow_len[i] = rs - b;
        // only the last spanning entry leaves a remainder
        if (e > re) begin
          have_rem = 1'b1;
          rem_base = re;
          rem_len  = e - re;
        end
      end else if (e <= re) begin
        shadow_type[i] = rsv_code;
      end else begin
        shadow_base[i] = re;
        shadow_len[i]  = e - re;
      end
    end
    if (have_rem && rem_len != 0 && !shadow_append(rem_base, rem_len, ram_code))
      return StatusFull;
    return StatusOk;
  endfunction

  function automatic map_result_t predict_map(map_cmd_t c);
    map_result_t r;
    r = '0;
    case (c.kind)
      KindClear: shadow_count = 0;
      KindAppend: begin
        if (!shadow_append(c.base, c.length, c.etype)) r.status = StatusFull;
      end
      KindCarve: r.status = shadow_carve(c.rstart, c.rend);
      default: begin
        if (c.index < shadow_count) begin
          r.base   = shadow_base[c.index];
          r.length = shadow_len[c.index];
          r.etype  = shadow_type[c.index];
        end else begin
          r.status = StatusOor;
        end
      end
    endcase
    r.used = 6'(shadow_count);
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Address at or near the edge of an entry in use
  function automatic logic [63:0] entry_point();
    int unsigned j;
    logic [63:0] p;
    j = $urandom_range(0, shadow_count - 1);
    p = shadow_base[j];
    if ($urandom_range(0, 1) == 1) p = p + shadow_len[j];
    case ($urandom_range(0, 2))
      0:       return p;
      1:       return p - 64'($urandom_range(1, 'h200));
      default: return p + 64'($urandom_range(1, 'h200));
    endcase
  endfunction

  function automatic map_cmd_t random_cmd();
    map_cmd_t c;
    int       pick;
    c.index  = 5'($urandom);
    c.base   = rand64();
    c.length = rand64();
    c.etype  = $urandom;
    c.rstart = rand64();
    c.rend   = rand64();
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      c.kind = KindClear;
    end else if (pick < 40) begin
      c.kind = KindAppend;
      case ($urandom_range(0, 9))
        0, 1: ;
        2:       c.base = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 'hFFFF));
        default: c.base = 64'($urandom_range(0, 255)) << 8;
      endcase
      case ($urandom_range(0, 9))
        0:       c.length = '0;
        1:       ;
        default: c.length = 64'($urandom_range(1, 'h3000));
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 7) c.etype = ram_code;
      else if (pick < 9) c.etype = rsv_code;
    end else if (pick < 72) begin
      c.kind = KindCarve;
      if (shadow_count != 0 && $urandom_range(0, 9) < 7) begin
        c.rstart = entry_point();
        if ($urandom_range(0, 1) == 1) c.rend = entry_point();
        else c.rend = c.rstart + 64'($urandom_range(0, 'h3000));
      end else if ($urandom_range(0, 2) != 0) begin
        c.rstart = 64'($urandom_range(0, 'h10000));
        c.rend   = c.rstart + 64'($urandom_range(0, 'h4000));
      end
    end else begin
      c.kind = KindRead;
      if (shadow_count != 0 && $urandom_range(0, 9) < 7)
        c.index = 5'($urandom_range(0, shadow_count - 1));
    end
    return c;
  endfunction

  function automatic plan_row_t plan(logic [1:0] kind, logic [4:0] idx, logic [63:0] b,
                                     logic [63:0] l, logic [31:0] t, logic [63:0] rs,
                                     logic [63:0] re, logic fixed, logic [5:0] fu,
                                     logic [1:0] fs, logic fill);
    plan_row_t p;
    p.cmd.kind     = kind;
    p.cmd.index    = idx;
    p.cmd.base     = b;
    p.cmd.length   = l;
    p.cmd.etype    = t;
    p.cmd.rstart   = rs;
    p.cmd.rend     = re;
    p.fixed        = fixed;
    p.fixed_used   = fu;
    p.fixed_status = fs;
    p.fill         = fill;
    return p;
  endfunction

  task automatic issue(map_cmd_t c, logic fixed, logic [5:0] fu, logic [1:0] fs);
    map_result_t r;
    start_i        <= 1'b1;
    start_up        = 1'b1;
    kind_i         <= c.kind;
    index_i        <= c.index;
    entry_base_i   <= c.base;
    entry_length_i <= c.length;
    entry_type_i   <= c.etype;
    range_start_i  <= c.rstart;
    range_end_i    <= c.rend;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    r = predict_map(c);
    if (fixed) begin
      r        = '0;
      r.used   = fu;
      r.status = fs;
    end
    pending_q.push_back(r);
  endtask

  task automatic lower_start();
    if (start_up) begin
      start_i <= 1'b0;
      start_up = 1'b0;
    end
  endtask

  task automatic idle(int unsigned n);
    lower_start();
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    lower_start();
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(logic [31:0] ram, logic [31:0] rsv);
    drain();
    repeat (4) @(posedge clk_i);
    for (int k = 0; k < 2; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (k == 0) ? CfgRamType : CfgReservedType;
      cfg_data_i  <= (k == 0) ? ram : rsv;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      if (k == 0) ram_code = ram;
      else rsv_code = rsv;
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    map_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: used_count %0d status %0d",
               used_count_o, status_o);
        fail_count++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_base_o !== exp_r.base) begin
          $error("out_base: expected %h, actual %h", exp_r.base, out_base_o);
          fail_count++;
        end
        if (out_length_o !== exp_r.length) begin
          $error("out_length: expected %h, actual %h", exp_r.length, out_length_o);
          fail_count++;
        end
        if (out_type_o !== exp_r.etype) begin
          $error("out_type: expected %h, actual %h", exp_r.etype, out_type_o);
          fail_count++;
        end
        if (used_count_o !== exp_r.used) begin
          $error("used_count: expected %0d, actual %0d", exp_r.used, used_count_o);
          fail_count++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(64'd8_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    map_cmd_t    filler;
    logic [31:0] ram_sel;
    logic [31:0] rsv_sel;
    bit          calm;
    int unsigned pick;

    fail_count   = 0;
    shadow_count = 0;
    ram_code     = 32'd1;
    rsv_code     = 32'd2;
    start_up     = 1'b0;

    // kind idx base length type start end fixed used status fill
    plan_q.push_back(plan(KindRead, 5'd0, 0, 0, 0, 0, 0, 1, 6'd0, StatusOor, 0));
    plan_q.push_back(plan(KindRead, 5'd31, 0, 0, 0, 0, 0, 1, 6'd0, StatusOor, 0));
    plan_q.push_back(plan(KindCarve, 5'd0, 0, 0, 0, 64'h0, '1, 1, 6'd0, StatusOk, 0));
    plan_q.push_back(plan(KindAppend, 5'd0, '1, '1, '1, 0, 0, 1, 6'd1, StatusOk, 0));
    plan_q.push_back(plan(KindRead, 5'd0, 0, 0, 0, 0, 0, 0, 6'd0, StatusOk, 0));
    plan_q.push_back(plan(KindClear, 5'd0, 0, 0, 0, 0, 0, 1, 6'd0, StatusOk, 0));
    plan_q.push_back(plan(KindAppend, 5'd0, 'h1000, 'h1000, 1, 0, 0, 1, 6'd1, StatusOk, 0));
    plan_q.push_back(plan(KindAppend, 5'd0, 'h3000, 'h2000, 1, 0, 0, 1, 6'd2, StatusOk, 0));
    plan_q.push_back(plan(KindAppend, 5'd0, 'h8000, 'h1000, 1, 0, 0, 1, 6'd3, StatusOk, 0));
    plan_q.push_back(plan(KindAppend, 5'd0, 'h10000, 'h10000, 1, 0, 0, 1, 6'd4, StatusOk, 0));
    plan_q.push_back(plan(KindAppend, 5'd0, 64'hFFFF_FFFF_FFFF_F000, 'h2000, 1, 0, 0,
                          1, 6'd5, StatusOk, 0));
    plan_q.push_back(plan(KindAppend, 5'd0, 'h20000, 'h100, 7, 0, 0, 1, 6'd6, StatusOk, 0));
    // tail trim of one entry, head trim of the next
    plan_q.push_back(plan(KindCarve, 5'd0, 0, 0, 0, 'h1800, 'h3800, 0, 6'd0, StatusOk, 0));
    // entry wholly inside
    plan_q.push_back(plan(KindCarve, 5'd0, 0, 0, 0, 'h8000, 'h9000, 0, 6'd0, StatusOk, 0));
    // split with remainder
    plan_q.push_back(plan(KindCarve, 5'd0, 0, 0, 0, 'h14000, 'h18000, 0, 6'd0, StatusOk, 0));
    // non-RAM entry left alone
    plan_q.push_back(plan(KindCarve, 5'd0, 0, 0, 0, 'h20000, 'h20100, 0, 6'd0, StatusOk, 0));
    // wrapping range and wrapping entry
    plan_q.push_back(plan(KindCarve, 5'd0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_F800, 0,
                          0, 6'd0, StatusOk, 0));
    plan_q.push_back(plan(KindAppend, 5'd0, 'h100000, 'h100000, 1, 0, 0, 0, 6'd0, StatusOk, 0));
    plan_q.push_back(plan(KindAppend, 5'd0, 'h180000, 'h100000, 1, 0, 0, 0, 6'd0, StatusOk, 0));
    // two spanning entries, the later remainder wins
    plan_q.push_back(plan(KindCarve, 5'd0, 0, 0, 0, 'h1C0000, 'h1D0000, 0, 6'd0, StatusOk, 0));
    plan_q.push_back(plan(KindRead, 5'd9, 0, 0, 0, 0, 0, 0, 6'd0, StatusOk, 0));
    plan_q.push_back(plan(KindRead, 5'd10, 0, 0, 0, 0, 0, 1, 6'd10, StatusOor, 0));
    plan_q.push_back(plan(KindAppend, 5'd0, 'h5000, 'h10, 1, 0, 0, 1, 6'd32, StatusFull, 1));
    // split on a full table drops the remainder
    plan_q.push_back(plan(KindCarve, 5'd0, 0, 0, 0, 64'hA000_0800, 64'hA000_1000,
                          0, 6'd0, StatusOk, 0));
    plan_q.push_back(plan(KindRead, 5'd31, 0, 0, 0, 0, 0, 0, 6'd0, StatusOk, 0));
    plan_q.push_back(plan(KindClear, 5'd0, 0, 0, 0, 0, 0, 1, 6'd0, StatusOk, 0));
    plan_q.push_back(plan(KindRead, 5'd0, 0, 0, 0, 0, 0, 1, 6'd0, StatusOor, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[k]) begin
      if (plan_q[k].fill) begin
        while (shadow_count < MaxEntries) begin
          filler        = '0;
          filler.kind   = KindAppend;
          filler.base   = 64'h1000_0000 * shadow_count;
          filler.length = 64'h1000_0000;
          filler.etype  = ram_code;
          issue(filler, 1'b0, 6'd0, StatusOk);
        end
      end
      issue(plan_q[k].cmd, plan_q[k].fixed, plan_q[k].fixed_used, plan_q[k].fixed_status);
      if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 6));
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin ram_sel = 32'd1;          rsv_sel = 32'd2;          end
        1:       begin ram_sel = 32'd0;          rsv_sel = 32'hFFFF_FFFF;  end
        2:       begin ram_sel = 32'hFFFF_FFFF;  rsv_sel = 32'd0;          end
        3:       begin ram_sel = 32'd5;          rsv_sel = 32'd5;          end
        default: begin ram_sel = $urandom;       rsv_sel = $urandom;       end
      endcase
      write_config(ram_sel, rsv_sel);
      calm = 1'b0;
      for (int n = 0; n < 325; n++) begin
        if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
        issue(random_cmd(), 1'b0, 6'd0, StatusOk);
        // now and then hold the sender until the block has answered everything; otherwise, unless calm, pause at random
        if ($urandom_range(0, 99) == 0) begin
          drain();
        end else if (!calm) begin
          pick = $urandom_range(0, 99);
          if (pick >= 93) idle($urandom_range(8, 40));
          else if (pick >= 55) idle($urandom_range(1, 3));
        end
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mmrc_pkg.sv
rtl/memory_map_range_carver.sv
bench/memory_map_range_carver_test.sv
